// ----- rtl/tep_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tep_pkg
// Shared constants, codes and types of the timed event pool scheduler.
// ----------------------------------------------------------------------------
package tep_pkg;

    // pool geometry
    localparam int SLOTS         = 8;
    localparam int PAYLOAD_BYTES = 32;
    localparam int WORDS         = (PAYLOAD_BYTES + 7) / 8;
    localparam int SLOT_W        = $clog2(SLOTS);
    localparam int WORD_W        = 2;                    // fill word index, saturates at 3
    localparam int MEM_DEPTH     = SLOTS * (1 << WORD_W);
    localparam int WCNT_W        = 3;
    localparam int LEN_W         = 6;

    // stream widths
    localparam int IN_TDATA_W    = 168;
    localparam int OUT_TDATA_W   = 136;

    localparam logic [WORD_W-1:0] FILL_WORD_MAX = '1;

    // input function codes
    localparam logic FUNC_ENQ  = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef logic [SLOT_W-1:0] slot_idx_t;
    typedef logic [WORD_W-1:0] word_idx_t;
    typedef logic [WCNT_W-1:0] wcnt_t;
    typedef logic [LEN_W-1:0]  len_t;

    typedef enum logic [1:0] {
        KIND_STATUS  = 2'd0,
        KIND_HEADER  = 2'd1,
        KIND_PAYLOAD = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STAT_ACCEPTED  = 2'd0,
        STAT_TOO_LONG  = 2'd1,
        STAT_POOL_FULL = 2'd2
    } status_t;

    // one input beat, unpacked
    typedef struct packed {
        logic               func;
        logic signed [63:0] stamp;
        logic [31:0]        dest;
        logic [7:0]         byte_count;
        logic [63:0]        data_word;
        logic               last;
    } in_beat_t;

    // one result beat
    typedef struct packed {
        kind_t       kind;
        status_t     status;
        logic [31:0] dest;
        len_t        byte_count;
        logic [63:0] data_word;
        logic        last;
        logic [31:0] dropped;
    } out_beat_t;

    // requests from the sequencer to the slot pool
    typedef struct packed {
        slot_idx_t   fill_slot;
        logic        claim;
        logic [63:0] due;
        logic [31:0] dest;
        len_t        len;
        logic        commit;
        wcnt_t       wcnt;
        logic        wr;
        word_idx_t   wr_word;
        logic [63:0] wr_data;
        slot_idx_t   scan_slot;
        logic        free;
        logic        rd;
        word_idx_t   rd_word;
    } pool_req_t;

    // slot pool view at the scan slot
    typedef struct packed {
        logic [SLOTS-1:0] busy;
        logic [63:0]      due;
        logic [31:0]      dest;
        len_t             len;
        wcnt_t            wcnt;
        logic [63:0]      rd_data;
    } pool_rsp_t;

endpackage

// ----- rtl/tep_pool.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tep_pool
// Slot storage: busy flags, slot headers and the payload word memory.
// ----------------------------------------------------------------------------
module tep_pool (
    input  logic               clk,
    input  logic               rst_n,
    input  tep_pkg::pool_req_t req,
    output tep_pkg::pool_rsp_t rsp
);
    import tep_pkg::*;

    logic [SLOTS-1:0] busy_reg;
    logic [63:0]      due_reg  [SLOTS];
    logic [31:0]      dest_reg [SLOTS];
    len_t             len_reg  [SLOTS];
    wcnt_t            wcnt_reg [SLOTS];
    logic [63:0]      mem      [MEM_DEPTH];
    logic [63:0]      rd_data_reg;

    // busy flags: set when a run completes, cleared when the slot fires
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else
        begin
            if (req.commit)
            begin
                busy_reg[req.fill_slot] <= 1'b1;
            end
            if (req.free)
            begin
                busy_reg[req.scan_slot] <= 1'b0;
            end
        end
    end

    // slot headers
    always_ff @(posedge clk)
    begin
        if (req.claim)
        begin
            due_reg[req.fill_slot]  <= req.due;
            dest_reg[req.fill_slot] <= req.dest;
            len_reg[req.fill_slot]  <= req.len;
        end
        if (req.commit)
        begin
            wcnt_reg[req.fill_slot] <= req.wcnt;
        end
    end

    // payload memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (req.wr)
        begin
            mem[{req.fill_slot, req.wr_word}] <= req.wr_data;
        end
        if (req.rd)
        begin
            rd_data_reg <= mem[{req.scan_slot, req.rd_word}];
        end
    end

    assign rsp.busy    = busy_reg;
    assign rsp.due     = due_reg[req.scan_slot];
    assign rsp.dest    = dest_reg[req.scan_slot];
    assign rsp.len     = len_reg[req.scan_slot];
    assign rsp.wcnt    = wcnt_reg[req.scan_slot];
    assign rsp.rd_data = rd_data_reg;

endmodule

// ----- rtl/tep_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tep_ctrl
// Sequencer: enqueue run handling, due-time scan with one shared compare,
// fired event readout and the result register.
// ----------------------------------------------------------------------------
module tep_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tep_pkg::in_beat_t   in_beat,
    output logic                out_valid,
    input  logic                out_ready,
    output tep_pkg::out_beat_t  out_beat,
    output tep_pkg::pool_req_t  req,
    input  tep_pkg::pool_rsp_t  rsp
);
    import tep_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_SCAN = 5'b00010,
        ST_SEL  = 5'b00100,
        ST_HDR  = 5'b01000,
        ST_WORD = 5'b10000
    } state_t;

    typedef enum logic [3:0] {
        FILL_IDLE = 4'b0001,
        FILL_DATA = 4'b0010,
        FILL_LONG = 4'b0100,
        FILL_FULL = 4'b1000
    } fill_mode_t;

    state_t             state_reg, state_next;
    fill_mode_t         fill_mode_reg, fill_mode_next;
    word_idx_t          fill_word_reg, fill_word_next;
    slot_idx_t          fill_slot_reg, fill_slot_next;
    len_t               fill_len_reg, fill_len_next;
    logic [31:0]        drop_reg, drop_next;
    logic signed [63:0] now_reg, now_next;
    slot_idx_t          idx_reg, idx_next;
    logic [SLOTS-1:0]   mask_reg, mask_next;
    word_idx_t          word_reg, word_next;
    logic               out_valid_reg, out_valid_next;
    out_beat_t          out_reg, out_next;

    logic               out_free;
    logic               in_fire;
    logic               free_found;
    slot_idx_t          free_slot;
    logic [31:0]        drop_inc;
    fill_mode_t         eq_mode;
    slot_idx_t          eq_slot;
    len_t               eq_len;
    word_idx_t          eq_fw;
    logic [31:0]        eq_drop;
    logic               eq_claim;
    logic [63:0]        eq_data;
    logic               eq_wr;
    wcnt_t              eq_wcnt;
    word_idx_t          eq_fw_after;
    status_t            eq_status;
    logic               hit;
    logic [SLOTS-1:0]   mask_upd;
    logic               rest_zero;
    logic [3:0]         nw_raw;
    wcnt_t              nw;
    logic               word_is_last;

    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign in_fire  = in_valid && in_ready;
    assign drop_inc = (drop_reg == '1) ? drop_reg : drop_reg + 32'd1;

    // lowest free slot
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int s = SLOTS - 1; s >= 0; s--)
        begin
            if (!rsp.busy[s])
            begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(s);
            end
        end
    end

    // enqueue word: admission on the first word, then store
    always_comb
    begin
        eq_mode  = fill_mode_reg;
        eq_slot  = fill_slot_reg;
        eq_len   = fill_len_reg;
        eq_fw    = fill_word_reg;
        eq_drop  = drop_reg;
        eq_claim = 1'b0;
        if (fill_mode_reg == FILL_IDLE)
        begin
            eq_fw = '0;
            if (in_beat.byte_count > 8'(PAYLOAD_BYTES))
            begin
                eq_mode = FILL_LONG;
                eq_drop = drop_inc;
            end
            else if (free_found)
            begin
                eq_mode  = FILL_DATA;
                eq_slot  = free_slot;
                eq_len   = LEN_W'(in_beat.byte_count);
                eq_claim = 1'b1;
            end
            else
            begin
                eq_mode = FILL_FULL;
                eq_drop = drop_inc;
            end
        end

        // bytes past the length are zeroed
        for (int b = 0; b < 8; b++)
        begin
            eq_data[b*8 +: 8] = (LEN_W'({eq_fw, 3'(b)}) < eq_len) ?
                                in_beat.data_word[b*8 +: 8] : 8'd0;
        end
        eq_wr = (eq_mode == FILL_DATA) && (WCNT_W'(eq_fw) < WCNT_W'(WORDS))
                && (LEN_W'({eq_fw, 3'b000}) < eq_len);

        eq_wcnt = WCNT_W'(eq_fw) + WCNT_W'(1);
        if (eq_wcnt > WCNT_W'(WORDS))
        begin
            eq_wcnt = WCNT_W'(WORDS);
        end
        eq_fw_after = (eq_fw == FILL_WORD_MAX) ? eq_fw : eq_fw + WORD_W'(1);

        if (eq_mode == FILL_DATA)
        begin
            eq_status = STAT_ACCEPTED;
        end
        else if (eq_mode == FILL_LONG)
        begin
            eq_status = STAT_TOO_LONG;
        end
        else
        begin
            eq_status = STAT_POOL_FULL;
        end
    end

    // shared due-time compare and readout helpers
    always_comb
    begin
        hit               = rsp.busy[idx_reg] && ($signed(rsp.due) <= now_reg);
        mask_upd          = mask_reg;
        mask_upd[idx_reg] = hit;
        rest_zero         = (mask_reg & ~(SLOTS'(1) << idx_reg)) == '0;
        nw_raw            = 4'((7'(rsp.len) + 7'd7) >> 3);
        nw                = (nw_raw > 4'(WORDS)) ? WCNT_W'(WORDS) : WCNT_W'(nw_raw);
        word_is_last      = (WCNT_W'(word_reg) + WCNT_W'(1)) == nw;
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        fill_mode_next = fill_mode_reg;
        fill_word_next = fill_word_reg;
        fill_slot_next = fill_slot_reg;
        fill_len_next  = fill_len_reg;
        drop_next      = drop_reg;
        now_next       = now_reg;
        idx_next       = idx_reg;
        mask_next      = mask_reg;
        word_next      = word_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        req           = '0;
        req.fill_slot = eq_slot;
        req.scan_slot = idx_reg;
        req.due       = in_beat.stamp;
        req.dest      = in_beat.dest;
        req.len       = eq_len;
        req.wcnt      = eq_wcnt;
        req.wr_word   = eq_fw;
        req.wr_data   = eq_data;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && (in_beat.func == FUNC_TICK))
                begin
                    now_next   = in_beat.stamp;
                    idx_next   = '0;
                    mask_next  = '0;
                    state_next = ST_SCAN;
                end
                else if (in_fire)
                begin
                    req.claim      = eq_claim;
                    req.wr         = eq_wr;
                    fill_slot_next = eq_slot;
                    fill_len_next  = eq_len;
                    drop_next      = eq_drop;
                    if (in_beat.last)
                    begin
                        req.commit         = (eq_mode == FILL_DATA);
                        fill_mode_next     = FILL_IDLE;
                        fill_word_next     = '0;
                        out_next           = '0;
                        out_next.kind      = KIND_STATUS;
                        out_next.status    = eq_status;
                        out_next.last      = 1'b1;
                        out_next.dropped   = eq_drop;
                        out_valid_next     = 1'b1;
                    end
                    else
                    begin
                        fill_mode_next = eq_mode;
                        fill_word_next = (eq_mode == FILL_DATA) ? eq_fw_after : eq_fw;
                    end
                end
            end

            // one slot compared per cycle
            ST_SCAN:
            begin
                mask_next = mask_upd;
                if (idx_reg == SLOT_W'(SLOTS - 1))
                begin
                    idx_next   = '0;
                    state_next = (mask_upd == '0) ? ST_IDLE : ST_SEL;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end

            ST_SEL:
            begin
                if (mask_reg[idx_reg])
                begin
                    state_next = ST_HDR;
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end

            ST_HDR:
            begin
                if (out_free)
                begin
                    out_next            = '0;
                    out_next.kind       = KIND_HEADER;
                    out_next.status     = STAT_ACCEPTED;
                    out_next.dest       = rsp.dest;
                    out_next.byte_count = rsp.len;
                    out_next.last       = rest_zero && (nw == '0);
                    out_next.dropped    = drop_reg;
                    out_valid_next      = 1'b1;
                    req.free            = 1'b1;
                    if (nw == '0)
                    begin
                        mask_next[idx_reg] = 1'b0;
                        idx_next           = idx_reg + SLOT_W'(1);
                        state_next         = rest_zero ? ST_IDLE : ST_SEL;
                    end
                    else
                    begin
                        word_next   = '0;
                        req.rd      = 1'b1;
                        req.rd_word = '0;
                        state_next  = ST_WORD;
                    end
                end
            end

            // payload words; read data is registered and lands in the cycle after the address
            ST_WORD:
            begin
                if (out_free)
                begin
                    out_next           = '0;
                    out_next.kind      = KIND_PAYLOAD;
                    out_next.status    = STAT_ACCEPTED;
                    out_next.data_word = (WCNT_W'(word_reg) < rsp.wcnt) ?
                                         rsp.rd_data : 64'd0;
                    out_next.last      = rest_zero && word_is_last;
                    out_next.dropped   = drop_reg;
                    out_valid_next     = 1'b1;
                    if (word_is_last)
                    begin
                        mask_next[idx_reg] = 1'b0;
                        idx_next           = idx_reg + SLOT_W'(1);
                        state_next         = rest_zero ? ST_IDLE : ST_SEL;
                    end
                    else
                    begin
                        word_next   = word_reg + WORD_W'(1);
                        req.rd      = 1'b1;
                        req.rd_word = word_reg + WORD_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_mode_reg <= FILL_IDLE;
            fill_word_reg <= '0;
            fill_slot_reg <= '0;
            drop_reg      <= '0;
            idx_reg       <= '0;
            mask_reg      <= '0;
            word_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_mode_reg <= fill_mode_next;
            fill_word_reg <= fill_word_next;
            fill_slot_reg <= fill_slot_next;
            drop_reg      <= drop_next;
            idx_reg       <= idx_next;
            mask_reg      <= mask_next;
            word_reg      <= word_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        fill_len_reg <= fill_len_next;
        now_reg      <= now_next;
        out_reg      <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_reg;

endmodule

// ----- rtl/timed_event_pool_scheduler.sv -----
`timescale 1ns / 1ps
// Enqueue: words wait for a free result register; the status beat is registered and shows
//   in the cycle after last. Tick: a due-time compare of every slot (one slot per cycle on a
//   single comparator), then per slot up to the last fired one a select step, plus per fired
//   slot a header beat and one beat per payload word (payload memory read port).
// Reset (rst_n, async, low): clears busy flags, drop counter and fill state; slot
//   contents stay undefined until written.
// ----------------------------------------------------------------------------
// timed_event_pool_scheduler
// Fixed pool of timed event slots fed by enqueue runs and fired by time ticks.
// ----------------------------------------------------------------------------
module timed_event_pool_scheduler (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // stamp[63:0], dest[95:64], byte_count[103:96], data_word[167:104]
    input  logic [tep_pkg::IN_TDATA_W-1:0]       s_tdata,
    // func
    input  logic                                 s_tuser,
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // status[1:0], dest_res[33:2], byte_count_res[39:34], data_word_res[103:40],
    // dropped_count[135:104]
    output logic [tep_pkg::OUT_TDATA_W-1:0]      m_tdata,
    // kind
    output logic [1:0]                           m_tuser,
    output logic                                 m_tlast
);
    import tep_pkg::*;

    in_beat_t  in_beat;
    out_beat_t out_beat;
    pool_req_t req;
    pool_rsp_t rsp;

    // unpack the input beat
    assign in_beat.func       = s_tuser;
    assign in_beat.stamp      = s_tdata[63:0];
    assign in_beat.dest       = s_tdata[95:64];
    assign in_beat.byte_count = s_tdata[103:96];
    assign in_beat.data_word  = s_tdata[167:104];
    assign in_beat.last       = s_tlast;

    tep_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_beat   (in_beat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_beat  (out_beat),
        .req       (req),
        .rsp       (rsp)
    );

    tep_pool u_pool (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // pack the result beat
    assign m_tdata = {out_beat.dropped, out_beat.data_word, out_beat.byte_count,
                      out_beat.dest, out_beat.status};
    assign m_tuser = out_beat.kind;
    assign m_tlast = out_beat.last;

endmodule
